FILE: sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// Serial frame deframer package
// Shared constants and the result record passed from the parser to the
// output stage.
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] SUM_BASE  = 8'd255;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef struct packed {
      logic        out_kind;
      logic [15:0] stream_id;
      logic [7:0]  payload_byte;
      logic [15:0] payload_index;
      logic [15:0] frame_length;
      logic        checksum_ok;
      logic        last;
   } result_type;

endpackage

FILE: sv/serial_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// Serial frame deframer top level
// Timing: a result is registered and appears on rsp_ in the cycle after its byte's transfer.
// Throughput: one byte per cycle, limited only by the one-entry result register.
// Reset: synchronous; parser returns to sync hunt, result register empties.
// ----------------------------------------------------------------------------
module serial_frame_deframer_top
   import sfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_out_kind,
   output logic [15:0] rsp_stream_id,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_payload_index,
   output logic [15:0] rsp_frame_length,
   output logic        rsp_checksum_ok,
   output logic        rsp_last
);

   // A byte transfer happens whenever the result register has room, which
   // includes the cycle in which its current result is being taken. The
   // parser state advances on every byte transfer, and any result the byte
   // causes is loaded into the result register on the same edge. Bytes that
   // cause no result (sync, header, hunted-past bytes) still need room, so
   // the stall decision never depends on the byte itself.

   logic       byte_accept;
   logic       parse_valid;
   result_type parse_result;
   logic       reg_space;
   result_type held;

   assign byte_accept = req_valid && req_ready;
   assign req_ready   = reg_space;

   sfd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .byte_accept  (byte_accept),
      .rx_byte      (req_rx_byte),
      .result_valid (parse_valid),
      .result       (parse_result)
   );

   // The result register decouples the two sides so that a waiting result
   // does not block the next byte once the downstream side takes it.
   sfd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (byte_accept && parse_valid),
      .load_data  (parse_result),
      .take       (rsp_ready),
      .space      (reg_space),
      .held_valid (rsp_valid),
      .held_data  (held)
   );

   assign rsp_out_kind      = held.out_kind;
   assign rsp_stream_id     = held.stream_id;
   assign rsp_payload_byte  = held.payload_byte;
   assign rsp_payload_index = held.payload_index;
   assign rsp_frame_length  = held.frame_length;
   assign rsp_checksum_ok   = held.checksum_ok;
   assign rsp_last          = held.last;

`ifndef SYNTH
   // The frame-end flag and the result kind always agree.
   a_last_matches_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == rsp_out_kind))
      else $error("rsp_last and rsp_out_kind disagree");

   // A frame-end verdict carries zero payload byte and index.
   a_verdict_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (rsp_payload_byte == 8'd0 && rsp_payload_index == 16'd0))
      else $error("frame-end result carries payload data");

   // Payload results never claim a checksum pass.
   a_payload_no_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> !rsp_checksum_ok)
      else $error("payload result has checksum_ok set");

   // With the result register empty the block must take a byte.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while result register empty");
`endif

endmodule

FILE: sv/sfd_parser.sv
// ----------------------------------------------------------------------------
// Serial frame deframer parser
// Holds the frame state and works out one byte per cycle while bytes are accepted:
// the next state and the result, if any, that the byte causes.
// ----------------------------------------------------------------------------
module sfd_parser
   import sfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        byte_accept,
   input  logic [7:0]  rx_byte,
   output logic        result_valid,
   output result_type  result
);

   typedef enum logic [2:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_ID_LO,
      PH_ID_HI,
      PH_LEN_LO,
      PH_LEN_HI,
      PH_PAYLOAD,
      PH_CHECK
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] topic_ff, topic_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] count_ff, count_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  sum_add;
   logic [15:0] count_inc;
   logic [15:0] len_full;

   assign sum_add   = sum_ff + rx_byte;
   assign count_inc = count_ff + 16'd1;
   assign len_full  = {rx_byte, len_ff[7:0]};

   always_comb begin
      phase_in     = phase_ff;
      topic_in     = topic_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      result_valid = 1'b0;
      result       = '{out_kind: KIND_PAYLOAD, stream_id: topic_ff, payload_byte: rx_byte,
                       payload_index: count_ff, frame_length: len_ff,
                       checksum_ok: 1'b0, last: 1'b0};
      case (phase_ff)
         PH_SYNC1: begin
            phase_in = (rx_byte == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
         end
         PH_SYNC2: begin
            if (rx_byte == SYNC_BYTE) begin
               phase_in = PH_ID_LO;
               sum_in   = '0;
               count_in = '0;
            end else begin
               phase_in = PH_SYNC1;
            end
         end
         PH_ID_LO: begin
            topic_in = {8'd0, rx_byte};
            sum_in   = sum_add;
            phase_in = PH_ID_HI;
         end
         PH_ID_HI: begin
            topic_in = {rx_byte, topic_ff[7:0]};
            sum_in   = sum_add;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            len_in   = {8'd0, rx_byte};
            sum_in   = sum_add;
            phase_in = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            len_in   = len_full;
            sum_in   = sum_add;
            count_in = '0;
            phase_in = (len_full == 16'd0) ? PH_CHECK : PH_PAYLOAD;
         end
         PH_PAYLOAD: begin
            sum_in       = sum_add;
            result_valid = 1'b1;
            count_in     = count_inc;
            if (count_inc == len_ff) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            result_valid         = 1'b1;
            result.out_kind      = KIND_VERDICT;
            result.payload_byte  = '0;
            result.payload_index = '0;
            result.checksum_ok   = ((SUM_BASE - sum_ff) == rx_byte);
            result.last          = 1'b1;
            phase_in             = PH_SYNC1;
            sum_in               = '0;
            count_in             = '0;
         end
         default: begin
            phase_in = PH_SYNC1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC1;
         topic_ff <= '0;
         len_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else if (byte_accept) begin
         phase_ff <= phase_in;
         topic_ff <= topic_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

FILE: sv/sfd_out_reg.sv
// ----------------------------------------------------------------------------
// Serial frame deframer result register
// Holds one result until the downstream side takes it and frees the input
// side whenever that register is empty or being emptied.
// ----------------------------------------------------------------------------
module sfd_out_reg
   import sfd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  load_data,
   input  logic        take,
   output logic        space,
   output logic        held_valid,
   output result_type  held_data
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign space      = !valid_ff || take;
   assign valid_in   = load || (valid_ff && !take);
   assign held_valid = valid_ff;
   assign held_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

endmodule
